@@ hw/rtl/content_length_frame_deframer_core_defines.svh @@
// assertion macros shared by the deframer rtl
`ifndef CONTENT_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define CONTENT_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication on clk, disabled during reset
`define CLFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, disabled during reset
`define CLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/clfd_pkg.sv @@
`timescale 1ns / 1ps
package clfd_pkg;

	// length counter width
	localparam int LenBits = 24;
	localparam int AccBits = LenBits + 1;
	localparam int MulBits = LenBits + 5;
	localparam int MaxBits = 24;
	localparam int KeyLen  = 15;

	// result kinds
	localparam logic [1:0] KindBody     = 2'd0;
	localparam logic [1:0] KindEmpty    = 2'd1;
	localparam logic [1:0] KindInvalid  = 2'd2;
	localparam logic [1:0] KindOverflow = 2'd3;

	// header line modes
	localparam logic [1:0] ModeKey    = 2'd0;
	localparam logic [1:0] ModeBlank  = 2'd1;
	localparam logic [1:0] ModeDigits = 2'd2;
	localparam logic [1:0] ModeIgnore = 2'd3;

	// length verdicts
	localparam logic [1:0] VerdNone    = 2'd0;
	localparam logic [1:0] VerdValid   = 2'd1;
	localparam logic [1:0] VerdInvalid = 2'd2;

	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [23:0] TailCrLfCr = 24'h0D0A0D;

	localparam logic [MaxBits-1:0] MaxLenReset = {MaxBits{1'b1}};

	typedef struct packed {
		logic               phase;
		logic [23:0]        recent;
		logic [4:0]         pos;
		logic [1:0]         mode;
		logic [1:0]         verdict;
		logic [AccBits-1:0] acc;
		logic [LenBits-1:0] remaining;
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] body;
		logic       last;
	} result_t;

	localparam state_t StateStart = '{
		phase:     1'b0,
		recent:    24'd0,
		pos:       5'd0,
		mode:      ModeKey,
		verdict:   VerdNone,
		acc:       '0,
		remaining: '0
	};

	// lower-case key text, one character per index
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = "c";
			4'd1:    ch = "o";
			4'd2:    ch = "n";
			4'd3:    ch = "t";
			4'd4:    ch = "e";
			4'd5:    ch = "n";
			4'd6:    ch = "t";
			4'd7:    ch = "-";
			4'd8:    ch = "l";
			4'd9:    ch = "e";
			4'd10:   ch = "n";
			4'd11:   ch = "g";
			4'd12:   ch = "t";
			4'd13:   ch = "h";
			4'd14:   ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ hw/rtl/clfd_stream_if.sv @@
`timescale 1ns / 1ps
interface clfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface clfd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] body_byte;
	logic       frame_last;

	modport source (output valid, output result_kind, output body_byte, output frame_last,
		input ready);
	modport sink (input valid, input result_kind, input body_byte, input frame_last,
		output ready);
endinterface

@@ hw/rtl/clfd_step.sv @@
`timescale 1ns / 1ps
module clfd_step (
	input  clfd_pkg::state_t                 cur,
	input  logic [7:0]                       data_byte,
	input  logic [clfd_pkg::MaxBits-1:0]     max_body_len,
	output clfd_pkg::state_t                 nxt,
	output clfd_pkg::result_t                res
);
	import clfd_pkg::*;

	logic [7:0]         lc;
	logic               is_digit;
	logic [7:0]         digit;
	logic [MulBits-1:0] acc_w;
	logic [MulBits-1:0] acc_v;
	logic [MulBits-1:0] cap;
	logic [LenBits-1:0] rem_dec;
	logic               key_hit;

	always_comb begin
		lc       = (data_byte inside {["A":"Z"]}) ? data_byte + 8'd32 : data_byte;
		is_digit = data_byte inside {[ChZero:ChNine]};
		digit    = data_byte - ChZero;
		acc_w    = MulBits'(cur.acc);
		// times ten as two shifts
		acc_v    = (acc_w << 3) + (acc_w << 1) + MulBits'(digit[3:0]);
		cap      = MulBits'(1) << LenBits;
		rem_dec  = (cur.remaining != '0) ? cur.remaining - LenBits'(1) : '0;
		key_hit  = (cur.pos < 5'(KeyLen)) && (lc == key_char(cur.pos[3:0]));
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.phase) begin
			// body pass-through
			res.valid = 1'b1;
			res.kind  = KindBody;
			res.body  = data_byte;
			res.last  = (cur.remaining <= LenBits'(1));
			nxt.remaining = rem_dec;
			if (rem_dec == '0) begin
				nxt = StateStart;
			end
		end else if (data_byte == ChLf && cur.recent == TailCrLfCr) begin
			// end of header
			nxt = StateStart;
			if (cur.verdict != VerdValid) begin
				res.valid = 1'b1;
				res.kind  = KindInvalid;
			end else if (cur.acc > AccBits'(max_body_len)) begin
				res.valid = 1'b1;
				res.kind  = KindOverflow;
			end else if (cur.acc == '0) begin
				res.valid = 1'b1;
				res.kind  = KindEmpty;
				res.last  = 1'b1;
			end else begin
				nxt.phase     = 1'b1;
				nxt.remaining = cur.acc[LenBits-1:0];
			end
		end else begin
			nxt.recent = {cur.recent[15:0], data_byte};
			if (data_byte == ChCr || data_byte == ChLf) begin
				if (cur.mode == ModeBlank) begin
					nxt.verdict = VerdInvalid;
				end
				nxt.mode = (nxt.verdict == VerdNone) ? ModeKey : ModeIgnore;
				nxt.pos  = 5'd0;
			end else begin
				case (cur.mode)
					ModeKey: begin
						if (key_hit) begin
							nxt.pos = cur.pos + 5'd1;
							if (cur.pos == 5'(KeyLen - 1)) begin
								nxt.mode = ModeBlank;
							end
						end else begin
							nxt.mode = ModeIgnore;
						end
					end
					ModeBlank: begin
						if (data_byte == ChSpace || data_byte == ChTab) begin
							nxt.mode = ModeBlank;
						end else if (is_digit) begin
							nxt.verdict = VerdValid;
							nxt.acc     = AccBits'(digit[3:0]);
							nxt.mode    = ModeDigits;
						end else begin
							nxt.verdict = VerdInvalid;
							nxt.mode    = ModeIgnore;
						end
					end
					ModeDigits: begin
						if (is_digit) begin
							nxt.acc = (acc_v > cap) ? AccBits'(cap) : AccBits'(acc_v);
						end else begin
							nxt.mode = ModeIgnore;
						end
					end
					default: begin
						nxt.mode = cur.mode;
					end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/content_length_frame_deframer_core.sv @@
// content-length deframer: one stream byte in, at most one result beat out
// an accepted byte passes through the input register, then its result beat leaves from the result register
// throughput: one byte per cycle, bounded only by output backpressure
// arst_n clears the pipeline valids and the parser to header scanning;
// max_body_len resets to all ones, payload registers are not reset
`timescale 1ns / 1ps
`include "content_length_frame_deframer_core_defines.svh"
module content_length_frame_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	clfd_in_if.sink                       src,
	clfd_out_if.source                    dst,
	input  logic                          cfg_wr_en,
	input  logic [clfd_pkg::MaxBits-1:0]  cfg_wr_data
);
	import clfd_pkg::*;

	// input register stage
	logic               valid_s1;
	logic [7:0]         byte_s1;

	// parser state and length limit
	state_t             state_q;
	state_t             state_next;
	result_t            step_res;
	logic [MaxBits-1:0] max_len_q;

	// result register
	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic [7:0]         out_body_q;
	logic               out_last_q;

	logic               advance;

	// the held byte moves on once the result register has room
	// (a byte that makes no result still needs that room, keeping the control simple)
	assign advance   = valid_s1 && (!out_valid_q || dst.ready);
	assign src.ready = !valid_s1 || advance;

	// limit register; write it only while idle (the user must keep to this, the block itself does not enforce it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// input stage: a new beat lands whenever the stage is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			byte_s1 <= src.data_byte;
		end
	end

	// one byte of parsing per cycle while the held byte advances
	clfd_step u_step (
		.cur          (state_q),
		.data_byte    (byte_s1),
		.max_body_len (max_len_q),
		.nxt          (state_next),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateStart;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register: loads on a producing step, empties when the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			out_kind_q <= step_res.kind;
			out_body_q <= step_res.body;
			out_last_q <= step_res.last;
		end
	end

	assign dst.valid       = out_valid_q;
	assign dst.result_kind = out_kind_q;
	assign dst.body_byte   = out_body_q;
	assign dst.frame_last  = out_last_q;

	// body phase always has bytes left to pass
	`CLFD_ASSERT_NOW(a_body_remaining, state_q.phase, state_q.remaining != '0, "body phase with zero remaining")
	// non-body results carry a zero byte
	`CLFD_ASSERT_NOW(a_zero_byte, out_valid_q && out_kind_q != KindBody, out_body_q == 8'd0, "non-body result with nonzero byte")
	// error results never close a frame, empty frames always do
	`CLFD_ASSERT_NOW(a_err_last, out_valid_q && (out_kind_q == KindInvalid || out_kind_q == KindOverflow), !out_last_q, "error result marked last")
	`CLFD_ASSERT_NOW(a_empty_last, out_valid_q && out_kind_q == KindEmpty, out_last_q, "empty frame without last")
	// a stalled result beat stays in the register
	`CLFD_ASSERT_NEXT(a_out_hold, out_valid_q && !dst.ready, out_valid_q && $stable(out_kind_q), "stalled result lost")

endmodule

@@ sim/content_length_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps
module content_length_frame_deframer_core_tb;
	import clfd_pkg::*;

	// one result beat as the block presents it
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] body;
		logic       last;
	} beat_t;

	// directed stimulus row: a byte, and optionally the beat it must produce
	typedef struct packed {
		logic [7:0] data;
		logic       typed;
		beat_t      beat;
	} dir_row_t;

	localparam beat_t Silent = '{KindBody, 8'h00, 1'b0};
	localparam logic [8*KeyLen-1:0] HdrKey = "content-length:";
	localparam logic [31:0] AccCap = 32'd1 << LenBits;
	localparam int NumDirRows = 29;
	localparam int NumSettings = 8;
	localparam int PhaseBytes = 225;
	localparam int SettleCycles = 8;

	// directed part: empty header, mixed-case key with a tab before the digit,
	// then a four byte body that itself looks like an end of header
	localparam dir_row_t DirRows [NumDirRows] = '{
		'{ChCr, 1'b0, Silent},
		'{ChLf, 1'b0, Silent},
		'{ChCr, 1'b0, Silent},
		'{ChLf, 1'b1, '{KindInvalid, 8'h00, 1'b0}},
		'{"C", 1'b0, Silent},
		'{"o", 1'b0, Silent},
		'{"n", 1'b0, Silent},
		'{"t", 1'b0, Silent},
		'{"e", 1'b0, Silent},
		'{"n", 1'b0, Silent},
		'{"t", 1'b0, Silent},
		'{"-", 1'b0, Silent},
		'{"L", 1'b0, Silent},
		'{"e", 1'b0, Silent},
		'{"n", 1'b0, Silent},
		'{"g", 1'b0, Silent},
		'{"t", 1'b0, Silent},
		'{"h", 1'b0, Silent},
		'{":", 1'b0, Silent},
		'{ChTab, 1'b0, Silent},
		'{"4", 1'b0, Silent},
		'{ChCr, 1'b0, Silent},
		'{ChLf, 1'b0, Silent},
		'{ChCr, 1'b0, Silent},
		'{ChLf, 1'b0, Silent},
		'{ChCr, 1'b1, '{KindBody, ChCr, 1'b0}},
		'{ChLf, 1'b1, '{KindBody, ChLf, 1'b0}},
		'{ChCr, 1'b1, '{KindBody, ChCr, 1'b0}},
		'{ChLf, 1'b1, '{KindBody, ChLf, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [MaxBits-1:0] cfg_wr_data;

	clfd_in_if  in_bus ();
	clfd_out_if out_bus ();

	// cfg_index 0 is implied: the block has a single register
	content_length_frame_deframer_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.src         (in_bus),
		.dst         (out_bus),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state, a private copy of the parser
	logic                in_body;
	logic [23:0]         recent;
	logic [4:0]          key_pos;
	logic [1:0]          line_mode;
	logic [1:0]          verdict;
	logic [AccBits-1:0]  len_acc;
	logic [LenBits-1:0]  body_left;
	logic [MaxBits-1:0]  max_len_setting;

	beat_t       awaited_beats [$];
	logic [7:0]  stream_q [$];
	beat_t       head_beat;

	bit          sender_idles;
	bit          receiver_stalls;
	int unsigned idle_pct;
	int unsigned bytes_sent;
	int unsigned beats_checked;
	int unsigned mismatches;
	int unsigned kind_count [4];

	function automatic logic [7:0] key_at(input int idx);
		return HdrKey[8*(KeyLen-1-idx) +: 8];
	endfunction

	function automatic void restart_header();
		in_body   = 1'b0;
		recent    = '0;
		key_pos   = '0;
		line_mode = ModeKey;
		verdict   = VerdNone;
		len_acc   = '0;
		body_left = '0;
	endfunction

	// advance the parser by one stream byte; returns 1 when a beat is due
	function automatic bit deframe_byte(input logic [7:0] c, output beat_t res);
		logic [7:0]         lc;
		logic [1:0]         verd;
		logic [AccBits-1:0] len;
		logic [31:0]        prod;
		res = Silent;
		// body bytes pass through without looking at them
		if (in_body) begin
			res.kind = KindBody;
			res.body = c;
			res.last = (body_left <= 1);
			if (body_left != 0)
				body_left = body_left - 1'b1;
			if (body_left == 0)
				restart_header();
			return 1'b1;
		end
		// final lf of cr lf cr lf closes the header
		if (c == ChLf && recent == TailCrLfCr) begin
			verd = verdict;
			len  = len_acc;
			restart_header();
			if (verd != VerdValid) begin
				res.kind = KindInvalid;
				return 1'b1;
			end
			if (len > max_len_setting) begin
				res.kind = KindOverflow;
				return 1'b1;
			end
			if (len == 0) begin
				res.kind = KindEmpty;
				res.last = 1'b1;
				return 1'b1;
			end
			in_body   = 1'b1;
			body_left = len[LenBits-1:0];
			return 1'b0;
		end
		recent = {recent[15:0], c};
		lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		if (c == ChCr || c == ChLf) begin
			// key seen but no digit before the end of line
			if (line_mode == ModeBlank)
				verdict = VerdInvalid;
			line_mode = (verdict == VerdNone) ? ModeKey : ModeIgnore;
			key_pos = '0;
			return 1'b0;
		end
		case (line_mode)
			ModeKey: begin
				if (key_pos < KeyLen && lc == key_at(key_pos)) begin
					key_pos = key_pos + 1'b1;
					if (key_pos == KeyLen)
						line_mode = ModeBlank;
				end else begin
					line_mode = ModeIgnore;
				end
			end
			ModeBlank: begin
				if (c >= ChZero && c <= ChNine) begin
					verdict   = VerdValid;
					len_acc   = c - ChZero;
					line_mode = ModeDigits;
				end else if (c != ChSpace && c != ChTab) begin
					verdict   = VerdInvalid;
					line_mode = ModeIgnore;
				end
			end
			ModeDigits: begin
				if (c >= ChZero && c <= ChNine) begin
					// saturate one past the largest length
					prod = len_acc * 10 + (c - ChZero);
					len_acc = (prod > AccCap) ? AccCap[AccBits-1:0] : prod[AccBits-1:0];
				end else begin
					line_mode = ModeIgnore;
				end
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// present one byte, hold it until accepted, then predict its beat
	task automatic send_byte(input logic [7:0] b, input bit typed, input beat_t typed_beat);
		beat_t res;
		bit    due;
		@(negedge clk);
		while (sender_idles && $urandom_range(0, 99) < idle_pct) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid     <= 1'b1;
		in_bus.data_byte <= b;
		do
			@(posedge clk);
		while (in_bus.ready !== 1'b1);
		bytes_sent++;
		due = deframe_byte(b, res);
		if (typed)
			awaited_beats.push_back(typed_beat);
		else if (due)
			awaited_beats.push_back(res);
	endtask

	// stop sending and let the block empty out
	task automatic drain();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (awaited_beats.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [MaxBits-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_len_setting = v;
	endtask

	// cr, lf or cr lf
	task automatic add_line_end();
		case ($urandom_range(0, 2))
			0: stream_q.push_back(ChCr);
			1: stream_q.push_back(ChLf);
			default: begin
				stream_q.push_back(ChCr);
				stream_q.push_back(ChLf);
			end
		endcase
	endtask

	task automatic add_terminator();
		stream_q.push_back(ChCr);
		stream_q.push_back(ChLf);
		stream_q.push_back(ChCr);
		stream_q.push_back(ChLf);
	endtask

	// some unrelated header text, never empty
	task automatic add_filler_line();
		int unsigned n;
		n = $urandom_range(1, 10);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: stream_q.push_back(8'("A" + $urandom_range(0, 25)));
				1: stream_q.push_back(":");
				2: stream_q.push_back(ChSpace);
				3: stream_q.push_back(8'("0" + $urandom_range(0, 9)));
				default: stream_q.push_back(8'("a" + $urandom_range(0, 25)));
			endcase
		end
	endtask

	// key in random letter case; a near miss spoils one character
	task automatic add_key(input bit near_miss);
		logic [7:0]  ch;
		int unsigned spoil;
		spoil = $urandom_range(0, KeyLen - 1);
		for (int i = 0; i < KeyLen; i++) begin
			ch = key_at(i);
			if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
				ch = ch - 8'd32;
			if (near_miss && i == spoil)
				ch = "x";
			stream_q.push_back(ch);
		end
	endtask

	task automatic add_decimal(input int unsigned v);
		logic [7:0] digs [$];
		if (v == 0)
			digs.push_back(ChZero);
		while (v != 0) begin
			digs.push_front(8'(ChZero + v % 10));
			v = v / 10;
		end
		foreach (digs[i])
			stream_q.push_back(digs[i]);
	endtask

	// one message: mostly well-formed, some noise and broken headers
	task automatic compose_message();
		int unsigned sel;
		int unsigned len;
		int unsigned r;
		bit          with_body;
		sel = $urandom_range(0, 99);
		with_body = 1'b0;
		len = 0;
		if (sel < 7) begin
			// raw noise, then an end of header to pull the parser back
			repeat ($urandom_range(1, 24)) stream_q.push_back(8'($urandom_range(0, 255)));
			add_terminator();
			return;
		end
		if (sel < 12) begin
			// empty header
			add_terminator();
			return;
		end
		if (sel < 17) begin
			// header cut short, the next message runs into it
			add_filler_line();
			return;
		end
		repeat ($urandom_range(0, 2)) begin
			add_filler_line();
			add_line_end();
		end
		if (sel < 25) begin
			// no usable length line
			if ($urandom_range(0, 1)) begin
				add_key(1'b1);
				add_decimal($urandom_range(0, 30));
			end else begin
				add_filler_line();
			end
			add_terminator();
			return;
		end
		add_key(1'b0);
		repeat ($urandom_range(0, 3)) stream_q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
		if (sel < 35) begin
			// key followed by a letter, a sign or nothing after the blanks, sometimes then digits
			case ($urandom_range(0, 2))
				0: begin
				end
				1: stream_q.push_back(8'("a" + $urandom_range(0, 25)));
				default: stream_q.push_back($urandom_range(0, 1) ? "+" : "-");
			endcase
			if ($urandom_range(0, 1))
				add_decimal($urandom_range(0, 99));
		end else if (sel < 43) begin
			// nine or more digits, far past the counter range
			stream_q.push_back(8'("1" + $urandom_range(0, 8)));
			repeat ($urandom_range(8, 11)) stream_q.push_back(8'(ChZero + $urandom_range(0, 9)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) stream_q.push_back(ChZero);
			r = $urandom_range(0, 99);
			if (r < 15)
				len = 0;
			else if (r < 30 && max_len_setting <= 80)
				len = max_len_setting + $urandom_range(0, 1);
			else if (r < 40)
				len = 1;
			else
				len = $urandom_range(2, 40);
			add_decimal(len);
			with_body = (len <= max_len_setting);
			if ($urandom_range(0, 3) == 0)
				stream_q.push_back($urandom_range(0, 1) ? ChSpace : ";");
		end
		// later lines, sometimes a second length line that must be ignored
		repeat ($urandom_range(0, 1)) begin
			add_line_end();
			if ($urandom_range(0, 1)) begin
				add_key(1'b0);
				add_decimal($urandom_range(0, 9));
			end else begin
				add_filler_line();
			end
		end
		add_terminator();
		if (with_body) begin
			repeat (len) begin
				case ($urandom_range(0, 9))
					0: stream_q.push_back(8'h00);
					1: stream_q.push_back(8'hFF);
					2, 3: stream_q.push_back(ChCr);
					4: stream_q.push_back(ChLf);
					default: stream_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	// receiver side: ready changes only at the falling edge
	always @(negedge clk)
		out_bus.ready <= receiver_stalls ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;

	// scoreboard: every accepted beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			if (awaited_beats.size() == 0) begin
				$error("beat with nothing expected: result_kind %0d body_byte %02h frame_last %0d",
					out_bus.result_kind, out_bus.body_byte, out_bus.frame_last);
				mismatches++;
			end else begin
				head_beat = awaited_beats.pop_front();
				beats_checked++;
				kind_count[head_beat.kind]++;
				if (out_bus.result_kind !== head_beat.kind) begin
					$error("result_kind: expected %0d, got %0d", head_beat.kind,
						out_bus.result_kind);
					mismatches++;
				end
				if (out_bus.body_byte !== head_beat.body) begin
					$error("body_byte: expected %02h, got %02h", head_beat.body,
						out_bus.body_byte);
					mismatches++;
				end
				if (out_bus.frame_last !== head_beat.last) begin
					$error("frame_last: expected %0d, got %0d", head_beat.last,
						out_bus.frame_last);
					mismatches++;
				end
			end
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("content_length_frame_deframer_core regression: fail");
		$finish;
	end

	initial begin
		logic [MaxBits-1:0] new_max;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_wr_data      = '0;
		in_bus.valid     = 1'b0;
		in_bus.data_byte = '0;
		out_bus.ready    = 1'b0;
		sender_idles     = 1'b0;
		receiver_stalls  = 1'b0;
		idle_pct         = 82;
		bytes_sent       = 0;
		beats_checked    = 0;
		mismatches       = 0;
		foreach (kind_count[i])
			kind_count[i] = 0;
		restart_header();
		max_len_setting = MaxLenReset;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table at full rate and reset length limit
		for (int i = 0; i < NumDirRows; i++)
			send_byte(DirRows[i].data, DirRows[i].typed, DirRows[i].beat);
		drain();

		// random phases: each its own length limit and idle pattern
		for (int p = 0; p < NumSettings; p++) begin
			case (p)
				1: new_max = '0;
				2: new_max = MaxLenReset;
				3: new_max = MaxBits'($urandom_range(1, 40));
				4: new_max = MaxBits'($urandom);
				5: new_max = MaxBits'(1);
				6: new_max = MaxBits'($urandom_range(0, 70));
				default: new_max = MaxLenReset;
			endcase
			// the first phase keeps the value from reset
			if (p != 0)
				write_max_len(new_max);
			sender_idles    = (p % 4 == 1) || (p % 4 == 3);
			receiver_stalls = (p % 4 == 2) || (p % 4 == 3);
			// both sides idle lightly when they idle together
			idle_pct        = (p % 4 == 3) ? 18 : 82;
			for (int n = 0; n < PhaseBytes; ) begin
				compose_message();
				while (stream_q.size() != 0) begin
					send_byte(stream_q.pop_front(), 1'b0, Silent);
					n++;
				end
			end
			drain();
		end

		$display("covered %0d stream bytes over %0d length limits and four idle patterns",
			bytes_sent, NumSettings);
		$display("checked %0d beats: %0d body, %0d empty, %0d invalid, %0d overflow",
			beats_checked, kind_count[KindBody], kind_count[KindEmpty],
			kind_count[KindInvalid], kind_count[KindOverflow]);
		if (mismatches == 0)
			$display("content_length_frame_deframer_core regression: pass");
		else
			$display("content_length_frame_deframer_core regression: fail");
		$finish;
	end

endmodule
